FILE: design/merkle_proof_verifier_sha256_defines.svh
// Assertion macros for the Merkle proof verifier.
// Included by every module that carries concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef MERKLE_PROOF_VERIFIER_SHA256_DEFINES_SVH
`define MERKLE_PROOF_VERIFIER_SHA256_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MPV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mpv_pkg.sv
// Shared constants for the Merkle proof verifier: item kinds, fail codes,
// register indexes and the SHA-256 round constants. No dependencies.
`timescale 1ns / 1ps
package mpv_pkg;

    localparam int unsigned MAX_DEPTH_DEF = 32;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_TX     = 3'd1;
    localparam logic [2:0] KIND_LEAF   = 3'd2;
    localparam logic [2:0] KIND_BOUND  = 3'd3;
    localparam logic [2:0] KIND_SIB    = 3'd4;

    localparam logic [2:0] FAIL_OK    = 3'd0;
    localparam logic [2:0] FAIL_ZERO  = 3'd1;
    localparam logic [2:0] FAIL_INDEX = 3'd2;
    localparam logic [2:0] FAIL_DEPTH = 3'd3;
    localparam logic [2:0] FAIL_DIR   = 3'd4;
    localparam logic [2:0] FAIL_BOUND = 3'd5;
    localparam logic [2:0] FAIL_ROOT  = 3'd6;
    localparam logic [2:0] FAIL_SEQ   = 3'd7;

    localparam logic [2:0] REG_ROOT0 = 3'd0;
    localparam logic [2:0] REG_ROOT1 = 3'd1;
    localparam logic [2:0] REG_ROOT2 = 3'd2;
    localparam logic [2:0] REG_ROOT3 = 3'd3;
    localparam logic [2:0] REG_COUNT = 3'd4;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] sha_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

FILE: design/merkle_proof_verifier_sha256.sv
// Top level of the SHA-256 Merkle inclusion proof verifier.
// Depends on mpv_pkg, mpv_sha_core and the defines header.
//
// Items arrive one per transaction: header, tx hash, leaf, bound proof, then one
// sibling per level; the item with last set yields one verdict. The block takes
// no item while it works. Header, tx and rejected items need no hashing; a leaf
// takes one SHA-256 block; a bound proof or a hashed sibling takes two blocks
// of 64 rounds in the shared compression unit, one round per cycle. A last item
// then derives the expected depth from leaf_count, one bit per cycle, and forms
// the verdict, which waits until the previous verdict has been taken. Root is
// read when the verdict is formed; leaf_count is read when the depth derivation
// starts and again when the verdict is formed.
`timescale 1ns / 1ps
`include "merkle_proof_verifier_sha256_defines.svh"
module merkle_proof_verifier_sha256 #(
    parameter int unsigned MAX_DEPTH = mpv_pkg::MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_item_kind,
    input  logic [63:0] i_data_word0,
    input  logic [63:0] i_data_word1,
    input  logic [63:0] i_data_word2,
    input  logic [63:0] i_data_word3,
    input  logic [31:0] i_index_value,
    input  logic [7:0]  i_direction,
    input  logic        i_last_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_proof_valid,
    output logic [2:0]  o_fail_reason,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import mpv_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_HASH, S_DEPTH, S_VERDICT} t_state;
    typedef enum logic [2:0] {
        PH_HEADER, PH_TX, PH_LEAF, PH_BOUND, PH_SIBS
    } t_phase;
    typedef enum logic [1:0] {JOB_LEAF, JOB_BOUND, JOB_SIB} t_job;

    localparam logic [6:0] SIB_SAT = 7'd127;

    t_state       r_state;
    t_phase       r_phase;
    t_job         r_job;
    logic [255:0] r_root;
    logic [31:0]  r_count;
    logic [255:0] r_run, r_tx, r_leaf, r_bound;
    logic [31:0]  r_index;
    logic [6:0]   r_sib;
    logic [2:0]   r_err;
    logic         r_last;
    logic         r_two, r_second;
    logic         r_core_start, r_core_init;
    logic [511:0] r_core_blk;
    logic [31:0]  r_tmp;
    logic [5:0]   r_dep;
    logic         r_out_valid, r_proof_valid;
    logic [2:0]   r_fail;

    logic         core_done;
    logic [255:0] core_digest;
    logic [255:0] in_data;
    logic         in_acc;
    logic [2:0]   code;

    mpv_sha_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_core_start),
        .i_init   (r_core_init),
        .i_block  (r_core_blk),
        .o_done   (core_done),
        .o_digest (core_digest)
    );

    function automatic logic [2:0] note_err(input logic [2:0] cur, input logic [2:0] c);
        if (cur == FAIL_OK || c == FAIL_SEQ || (cur != FAIL_SEQ && c < cur)) return c;
        return cur;
    endfunction

    assign in_data    = {i_data_word0, i_data_word1, i_data_word2, i_data_word3};
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_err == FAIL_SEQ || r_phase != PH_SIBS)          code = FAIL_SEQ;
        else if (r_count == 32'd0)                             code = FAIL_ZERO;
        else if (r_index >= r_count)                           code = FAIL_INDEX;
        else if (r_sib != {1'b0, r_dep} || 7'(r_dep) > 7'(MAX_DEPTH)) code = FAIL_DEPTH;
        else if (r_err != FAIL_OK)                             code = r_err;
        else if (r_run != r_root)                              code = FAIL_ROOT;
        else                                                   code = FAIL_OK;
    end

    always_ff @(posedge i_clk) begin
        r_core_start <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HEADER;
            r_sib       <= '0;
            r_err       <= FAIL_OK;
            r_index     <= '0;
            r_root      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_two       <= 1'b0;
            r_second    <= 1'b0;
            r_core_init <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ROOT0: r_root[255:192] <= i_cfg_data;
                    REG_ROOT1: r_root[191:128] <= i_cfg_data;
                    REG_ROOT2: r_root[127:64]  <= i_cfg_data;
                    REG_ROOT3: r_root[63:0]    <= i_cfg_data;
                    REG_COUNT: r_count         <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last <= i_last_item;
                        // by default no hashing; go straight to the depth step or stay idle
                        r_state <= i_last_item ? S_DEPTH : S_IDLE;
                        r_tmp   <= r_count - 32'd1;
                        r_dep   <= '0;
                        if (i_item_kind == KIND_HEADER && r_phase == PH_HEADER) begin
                            r_index <= i_index_value;
                            r_phase <= PH_TX;
                        end else if (i_item_kind == KIND_TX && r_phase == PH_TX) begin
                            r_tx    <= in_data;
                            r_phase <= PH_LEAF;
                        end else if (i_item_kind == KIND_LEAF && r_phase == PH_LEAF) begin
                            r_leaf       <= in_data;
                            r_phase      <= PH_BOUND;
                            r_job        <= JOB_LEAF;
                            r_two        <= 1'b0;
                            r_second     <= 1'b0;
                            r_core_blk   <= {in_data, 32'h80000000, 192'd0, 32'd256};
                            r_core_init  <= 1'b1;
                            r_core_start <= 1'b1;
                            r_state      <= S_HASH;
                        end else if (i_item_kind == KIND_BOUND && r_phase == PH_BOUND) begin
                            r_bound      <= in_data;
                            r_phase      <= PH_SIBS;
                            r_job        <= JOB_BOUND;
                            r_two        <= 1'b1;
                            r_second     <= 1'b0;
                            r_core_blk   <= {r_leaf, r_tx};
                            r_core_init  <= 1'b1;
                            r_core_start <= 1'b1;
                            r_state      <= S_HASH;
                        end else if (i_item_kind == KIND_SIB && r_phase == PH_SIBS) begin
                            if (r_sib < SIB_SAT) r_sib <= r_sib + 7'd1;
                            if (i_direction > 8'd1) begin
                                r_err <= note_err(r_err, FAIL_DIR);
                            end else if (r_sib < 7'(MAX_DEPTH)) begin
                                r_job        <= JOB_SIB;
                                r_two        <= 1'b1;
                                r_second     <= 1'b0;
                                r_core_blk   <= (i_direction == 8'd0) ? {r_run, in_data}
                                                                      : {in_data, r_run};
                                r_core_init  <= 1'b1;
                                r_core_start <= 1'b1;
                                r_state      <= S_HASH;
                            end
                        end else begin
                            r_err <= note_err(r_err, FAIL_SEQ);
                        end
                    end
                end
                S_HASH: begin
                    if (core_done) begin
                        if (r_two && !r_second) begin
                            // chain the padding block onto the first
                            r_second     <= 1'b1;
                            r_core_blk   <= {32'h80000000, 448'd0, 32'd512};
                            r_core_init  <= 1'b0;
                            r_core_start <= 1'b1;
                        end else begin
                            unique case (r_job)
                                JOB_LEAF, JOB_SIB: r_run <= core_digest;
                                JOB_BOUND: begin
                                    if (core_digest != r_bound)
                                        r_err <= note_err(r_err, FAIL_BOUND);
                                end
                                default: ;
                            endcase
                            // take leaf_count as it stands now
                            r_tmp   <= r_count - 32'd1;
                            r_state <= r_last ? S_DEPTH : S_IDLE;
                        end
                    end
                end
                S_DEPTH: begin
                    // ceil(log2 count): bit length of count - 1
                    if (r_tmp == 32'd0) begin
                        r_state <= S_VERDICT;
                    end else begin
                        r_tmp <= r_tmp >> 1;
                        r_dep <= r_dep + 6'd1;
                    end
                end
                S_VERDICT: begin
                    if (!r_out_valid) begin
                        r_out_valid   <= 1'b1;
                        r_fail        <= code;
                        r_proof_valid <= (code == FAIL_OK);
                        r_phase       <= PH_HEADER;
                        r_sib         <= '0;
                        r_err         <= FAIL_OK;
                        r_index       <= '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_proof_valid = r_proof_valid;
    assign o_fail_reason = r_fail;

    `MPV_ASSERT_IMPL(a_done_in_hash, core_done, r_state == S_HASH, "hash result outside hash state")
    `MPV_ASSERT_IMPL(a_verdict_code, r_out_valid, r_proof_valid == (r_fail == FAIL_OK),
        "verdict flag disagrees with fail code")
    `MPV_ASSERT_NEXT(a_out_hold, r_out_valid && !i_out_ready, r_out_valid,
        "pending verdict dropped")
endmodule

FILE: design/mpv_sha_core.sv
// Iterative SHA-256 compression unit: one round per cycle, 64 rounds then a
// feed-forward step per block. Depends on mpv_pkg and the defines header.
`timescale 1ns / 1ps
`include "merkle_proof_verifier_sha256_defines.svh"
module mpv_sha_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_init,
    input  logic [511:0] i_block,
    output logic         o_done,
    output logic [255:0] o_digest
);
    import mpv_pkg::*;

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_fin;
    logic        r_done;

    logic [31:0] w_new, t1, t2, s0, s1, e1, a0, ch, maj;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        e1    = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        a0    = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + e1 + ch + sha_k(r_rnd) + r_w[0];
        t2    = a0 + maj;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rnd  <= '0;
        end else if (i_start) begin
            for (int i = 0; i < 8; i++) begin
                if (i_init) begin
                    r_h[i] <= SHA_IV[255 - 32*i -: 32];
                    r_v[i] <= SHA_IV[255 - 32*i -: 32];
                end else begin
                    r_v[i] <= r_h[i];
                end
            end
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511 - 32*i -: 32];
            r_rnd  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            for (int i = 7; i > 0; i--) r_v[i] <= r_v[i-1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_rnd   <= r_rnd + 6'd1;
            if (r_rnd == 6'd63) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end else if (r_fin) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            r_fin  <= 1'b0;
            r_done <= 1'b1;
        end
    end

    assign o_done = r_done;
    always_comb begin
        for (int i = 0; i < 8; i++) o_digest[255 - 32*i -: 32] = r_h[i];
    end

    `MPV_ASSERT_IMPL(a_done_idle, o_done, !r_busy && !r_fin, "done while rounds still running")
    `MPV_ASSERT_NEXT(a_start_busy, i_start, r_busy, "start did not launch the rounds")
    `MPV_ASSERT_IMPL(a_busy_fin, r_busy, !r_fin, "round and feed-forward overlap")
endmodule
